>>> rtl/map_text_structure_counter_core_macros.svh
// assertion macros for the map text structure counter
`ifndef MAP_TEXT_STRUCTURE_COUNTER_CORE_MACROS_SVH
`define MAP_TEXT_STRUCTURE_COUNTER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge out of reset
`define MTSC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
// condition must never be seen out of reset
`define MTSC_NEVER(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(cond)) else $error(msg);
`else
`define MTSC_ASSERT(label, prop, msg)
`define MTSC_NEVER(label, cond, msg)
`endif

`endif

>>> rtl/mtsc_pkg.sv
// shared types and constants of the map text structure counter
package mtsc_pkg;

    // scanner modes
    typedef enum logic [1:0] {
        MODE_NORMAL  = 2'd0,
        MODE_QUOTE   = 2'd1,
        MODE_COMMENT = 2'd2,
        MODE_ENDED   = 2'd3
    } t_scan_mode;

    // characters the scanner reacts to
    localparam logic [7:0] CHAR_NUL     = 8'h00;
    localparam logic [7:0] CHAR_OPEN    = 8'h7B;
    localparam logic [7:0] CHAR_CLOSE   = 8'h7D;
    localparam logic [7:0] CHAR_PAREN   = 8'h28;
    localparam logic [7:0] CHAR_SLASH   = 8'h2F;
    localparam logic [7:0] CHAR_QUOTE   = 8'h22;
    localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;
    localparam logic [7:0] CHAR_TAB     = 8'h09;
    localparam logic [7:0] CHAR_CR      = 8'h0D;

    // result field widths
    localparam int ENTITY_W    = 24;
    localparam int FACE_W      = 23;
    localparam int DEPTH_OUT_W = 16;

    // parens per face and spare texture slots
    localparam int PAREN_GROUP = 3;
    localparam int TEX_SPARE   = 100;

    localparam logic [ENTITY_W-1:0] ENTITY_MAX = '1;
    localparam logic [FACE_W-1:0]   FACE_MAX   = '1;

    // one result transaction
    typedef struct packed {
        logic [ENTITY_W-1:0]           entity_total;
        logic [ENTITY_W-1:0]           brush_total;
        logic [FACE_W-1:0]             face_total;
        logic                          face_count_odd;
        logic [FACE_W-1:0]             texture_capacity;
        logic signed [DEPTH_OUT_W-1:0] final_depth;
    } t_result;

endpackage

>>> rtl/mtsc_scan.sv
// input register, scanner state and per-byte update with result formatting
module mtsc_scan #(
    parameter int COUNT_WIDTH = 24,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    input  logic             i_slot_free,
    output logic             o_res_valid,
    output mtsc_pkg::t_result o_res
);
    import mtsc_pkg::*;

    localparam int CE = (COUNT_WIDTH > ENTITY_W) ? COUNT_WIDTH : ENTITY_W;
    localparam int DE = (DEPTH_WIDTH > DEPTH_OUT_W) ? DEPTH_WIDTH : DEPTH_OUT_W;
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;
    localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MAX = {1'b0, {(DEPTH_WIDTH-1){1'b1}}};
    localparam logic signed [DEPTH_WIDTH-1:0] DEPTH_MIN = {1'b1, {(DEPTH_WIDTH-1){1'b0}}};
    localparam logic signed [DE-1:0] OUT_HI = DE'(32'sd32767);
    localparam logic signed [DE-1:0] OUT_LO = DE'(-32'sd32768);
    localparam logic [1:0] REM_TOP = 2'(PAREN_GROUP - 1);

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // scanner state
    t_scan_mode r_mode, n_mode;
    logic [7:0] r_held, n_held;
    logic       r_held_v, n_held_v;
    logic signed [DEPTH_WIDTH-1:0] r_depth, n_depth;
    logic [COUNT_WIDTH-1:0] r_ent, n_ent;
    logic [COUNT_WIDTH-1:0] r_bru, n_bru;
    logic [COUNT_WIDTH-1:0] r_pcnt, n_pcnt;
    logic [COUNT_WIDTH-1:0] r_pq, n_pq;
    logic [1:0]             r_pr, n_pr;

    logic       stage_go;
    logic       blank;
    logic       step_fire;
    logic       settle_fire;
    logic [7:0] settle_byte;
    logic [CE-1:0] ent_ext, bru_ext, q_ext;
    logic [FACE_W-1:0] faces;
    logic [FACE_W:0]   cap_sum;
    logic signed [DE-1:0] d_ext;

    // a last byte waits until the result slot is free
    assign stage_go = r_in_valid && (!r_in_last || i_slot_free);
    assign o_ready  = !r_in_valid || stage_go;
    assign o_res_valid = stage_go && r_in_last;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_valid <= 1'b1;
        end else if (stage_go) begin
            r_in_valid <= 1'b0;
        end
        if (i_valid && o_ready) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    // mode and held byte update, picks which held brace gets decided
    always_comb begin
        n_mode   = r_mode;
        n_held   = r_held;
        n_held_v = r_held_v;
        n_pcnt   = r_pcnt;
        n_pq     = r_pq;
        n_pr     = r_pr;
        step_fire = 1'b0;
        blank = r_in_byte inside {CHAR_SPACE, [CHAR_TAB:CHAR_CR]};
        if (r_mode != MODE_ENDED) begin
            if (r_in_byte == CHAR_NUL) begin
                step_fire = r_held_v;
                n_held_v  = 1'b0;
                n_mode    = MODE_ENDED;
            end else if (r_mode == MODE_QUOTE) begin
                if (r_in_byte == CHAR_QUOTE) begin
                    n_mode = MODE_NORMAL;
                end
            end else if (r_mode == MODE_COMMENT) begin
                if (r_in_byte == CHAR_NEWLINE) begin
                    n_mode = MODE_NORMAL;
                end
            end else if (r_held_v && r_held == CHAR_SLASH && r_in_byte == CHAR_SLASH) begin
                n_held_v = 1'b0;
                n_mode   = MODE_COMMENT;
            end else begin
                step_fire = r_held_v && blank;
                n_held_v  = 1'b0;
                if (r_in_byte == CHAR_QUOTE) begin
                    n_mode = MODE_QUOTE;
                end else if (r_in_byte inside {CHAR_SLASH, CHAR_OPEN, CHAR_CLOSE}) begin
                    n_held   = r_in_byte;
                    n_held_v = 1'b1;
                end else if (r_in_byte == CHAR_PAREN && r_pcnt != CNT_MAX) begin
                    n_pcnt = r_pcnt + 1'b1;
                    if (r_pr == REM_TOP) begin
                        n_pr = 2'd0;
                        n_pq = r_pq + 1'b1;
                    end else begin
                        n_pr = r_pr + 2'd1;
                    end
                end
            end
        end
        // at most one held byte is decided per transaction
        settle_fire = step_fire || (r_in_last && n_held_v);
        settle_byte = step_fire ? r_held : r_in_byte;
    end

    // brace decision and counting
    always_comb begin
        n_depth = r_depth;
        n_ent   = r_ent;
        n_bru   = r_bru;
        if (settle_fire) begin
            if (settle_byte == CHAR_OPEN) begin
                if (r_depth == '0) begin
                    if (r_ent != CNT_MAX) n_ent = r_ent + 1'b1;
                end else if (r_depth == DEPTH_WIDTH'(1)) begin
                    if (r_bru != CNT_MAX) n_bru = r_bru + 1'b1;
                end
                if (r_depth != DEPTH_MAX) n_depth = r_depth + 1'b1;
            end else if (settle_byte == CHAR_CLOSE) begin
                if (r_depth != DEPTH_MIN) n_depth = r_depth - 1'b1;
            end
        end
    end

    // result fields clamped to their widths
    always_comb begin
        ent_ext = CE'(n_ent);
        bru_ext = CE'(n_bru);
        q_ext   = CE'(n_pq);
        d_ext   = DE'($signed(n_depth));
        o_res.entity_total = (ent_ext > CE'(ENTITY_MAX)) ? ENTITY_MAX
                                                          : ent_ext[ENTITY_W-1:0];
        o_res.brush_total  = (bru_ext > CE'(ENTITY_MAX)) ? ENTITY_MAX
                                                          : bru_ext[ENTITY_W-1:0];
        faces = (q_ext > CE'(FACE_MAX)) ? FACE_MAX : q_ext[FACE_W-1:0];
        o_res.face_total     = faces;
        o_res.face_count_odd = (n_pr != 2'd0);
        cap_sum = {1'b0, faces} + (FACE_W+1)'(TEX_SPARE);
        o_res.texture_capacity = (cap_sum > {1'b0, FACE_MAX}) ? FACE_MAX
                                                               : cap_sum[FACE_W-1:0];
        if (d_ext > OUT_HI) begin
            o_res.final_depth = OUT_HI[DEPTH_OUT_W-1:0];
        end else if (d_ext < OUT_LO) begin
            o_res.final_depth = OUT_LO[DEPTH_OUT_W-1:0];
        end else begin
            o_res.final_depth = d_ext[DEPTH_OUT_W-1:0];
        end
    end

    // scanner state, back to reset after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (stage_go && r_in_last)) begin
            r_mode   <= MODE_NORMAL;
            r_held   <= '0;
            r_held_v <= 1'b0;
            r_depth  <= '0;
            r_ent    <= '0;
            r_bru    <= '0;
            r_pcnt   <= '0;
            r_pq     <= '0;
            r_pr     <= 2'd0;
        end else if (stage_go) begin
            r_mode   <= n_mode;
            r_held   <= n_held;
            r_held_v <= n_held_v;
            r_depth  <= n_depth;
            r_ent    <= n_ent;
            r_bru    <= n_bru;
            r_pcnt   <= n_pcnt;
            r_pq     <= n_pq;
            r_pr     <= n_pr;
        end
    end

endmodule

>>> rtl/mtsc_out.sv
// result register with output handshake
module mtsc_out (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_res_valid,
    input  mtsc_pkg::t_result i_res,
    output logic              o_slot_free,
    output logic              o_valid,
    input  logic              i_ready,
    output mtsc_pkg::t_result o_res
);
    import mtsc_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_slot_free = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    // hold a result until its transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_res_valid) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_res_valid) begin
            r_res <= i_res;
        end
    end

endmodule

>>> rtl/map_text_structure_counter_core.sv
// top level of the map text structure counter
//
//  channel | direction | payload                                        | handshake
//  --------+-----------+------------------------------------------------+------------------------
//  in      | input     | text_byte, last_byte                           | i_in_valid / o_in_ready
//  out     | output    | entity/brush/face totals, odd, capacity, depth | o_out_valid / i_out_ready
//
// one byte per cycle while the input is not blocked; each transaction passes through
// the input register and the scanner state updates as it leaves, so a result is
// registered in the result register when its last byte leaves the input register.
// reset (i_rst_n low at a clock edge) empties both registers and clears the scanner.
// a waiting result holds a last byte in the input register, which blocks the
// input until the result transaction completes; other bytes never wait.
`include "map_text_structure_counter_core_macros.svh"

module map_text_structure_counter_core #(
    parameter int COUNT_WIDTH = 24,
    parameter int DEPTH_WIDTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_text_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [mtsc_pkg::ENTITY_W-1:0]           o_entity_total,
    output logic [mtsc_pkg::ENTITY_W-1:0]           o_brush_total,
    output logic [mtsc_pkg::FACE_W-1:0]             o_face_total,
    output logic                                    o_face_count_odd,
    output logic [mtsc_pkg::FACE_W-1:0]             o_texture_capacity,
    output logic signed [mtsc_pkg::DEPTH_OUT_W-1:0] o_final_depth
);
    import mtsc_pkg::*;

    logic    res_valid;
    logic    slot_free;
    t_result scan_res;
    t_result out_res;
    logic    cap_ok;

    // scanner with input register
    mtsc_scan #(
        .COUNT_WIDTH (COUNT_WIDTH),
        .DEPTH_WIDTH (DEPTH_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_byte      (i_text_byte),
        .i_last      (i_last_byte),
        .i_slot_free (slot_free),
        .o_res_valid (res_valid),
        .o_res       (scan_res)
    );

    // result register
    mtsc_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_res_valid (res_valid),
        .i_res       (scan_res),
        .o_slot_free (slot_free),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_res       (out_res)
    );

    assign o_entity_total     = out_res.entity_total;
    assign o_brush_total      = out_res.brush_total;
    assign o_face_total       = out_res.face_total;
    assign o_face_count_odd   = out_res.face_count_odd;
    assign o_texture_capacity = out_res.texture_capacity;
    assign o_final_depth      = out_res.final_depth;

    // capacity is faces plus spare slots unless clamped
    assign cap_ok = (o_texture_capacity == FACE_MAX) ||
                    (ENTITY_W'(o_texture_capacity) ==
                     ENTITY_W'(o_face_total) + ENTITY_W'(TEX_SPARE));

    // a new result never overwrites one still waiting
    `MTSC_NEVER(a_no_overwrite, res_valid && !slot_free, "result overwritten while stalled")
    // output valid only rises after the scanner delivered a result
    `MTSC_ASSERT(a_rise_from_scan, $rose(o_out_valid) |-> $past(res_valid), "result from nowhere")
    // capacity consistent with the face total
    `MTSC_ASSERT(a_capacity, o_out_valid |-> cap_ok, "capacity mismatch")

endmodule
